// ----- src/fbc_pkg.sv -----
// Shared types, widths and a helper function of the frustum box culler.
package fbc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 24;
    localparam int ENTRY_W    = 32;
    localparam int CLIP_W     = 48;
    localparam int COEF_W     = CLIP_W + 1;
    localparam int LO_W       = 32;
    localparam int HI_W       = COEF_W - LO_W;
    localparam int OP_W       = LO_W + 1;
    localparam int PROD_W     = 2 * OP_W;
    localparam int ACC_W      = COEF_W + OP_W + 2;
    localparam int SIZE_W     = 11;
    localparam int CRD_W      = COORD_BITS + 1;
    localparam int MAT_N      = 16;
    localparam int PLANE_N    = 24;

    typedef enum logic [1:0] {
        CMD_LOAD_VIEW,
        CMD_LOAD_PROJ,
        CMD_REBUILD,
        CMD_TEST
    } cmd_t;

    typedef enum logic [1:0] {
        TERM_FLOOR,
        TERM_PLAIN,
        TERM_UPPER,
        TERM_DIRECT
    } term_t;

    typedef struct packed {
        logic  issue;
        logic  clear;
        term_t term;
    } mac_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RB_ISSUE,
        ST_RB_WAIT,
        ST_RB_TAKE,
        ST_BX_ISSUE,
        ST_BX_WAIT,
        ST_BX_TAKE,
        ST_PUSH
    } state_t;

    // Clamp an accumulator value to the signed clip range.
    function automatic logic signed [CLIP_W-1:0] sat_clip(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi_lim;
        logic signed [ACC_W-1:0] lo_lim;
        logic signed [CLIP_W-1:0] r;
        hi_lim = {{(ACC_W-CLIP_W+1){1'b0}}, {(CLIP_W-1){1'b1}}};
        lo_lim = ~hi_lim;
        if (v > hi_lim)
        begin
            r = hi_lim[CLIP_W-1:0];
        end
        else if (v < lo_lim)
        begin
            r = lo_lim[CLIP_W-1:0];
        end
        else
        begin
            r = v[CLIP_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- src/fbc_mac.sv -----
// Shared multiply-accumulate unit: registered product, then accumulate.
module fbc_mac import fbc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctrl_t                ctrl,
    input  logic signed [OP_W-1:0]   op_a,
    input  logic signed [OP_W-1:0]   op_b,
    input  logic signed [COEF_W-1:0] addend,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [COEF_W-1:0] addend_reg;
    mac_ctrl_t                ctrl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= op_a * op_b;
        addend_reg <= addend;
        acc_reg    <= acc_next;
    end

    always_comb
    begin
        case (ctrl_reg.term)
            TERM_FLOOR:  term = ACC_W'(prod_reg >>> FRAC_BITS);
            TERM_PLAIN:  term = ACC_W'(prod_reg);
            TERM_UPPER:  term = ACC_W'(prod_reg) <<< LO_W;
            TERM_DIRECT: term = ACC_W'(addend_reg);
            default:     term = '0;
        endcase
        if (!ctrl_reg.issue)
        begin
            acc_next = acc_reg;
        end
        else if (ctrl_reg.clear)
        begin
            acc_next = term;
        end
        else
        begin
            acc_next = acc_reg + term;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- src/frustum_box_culler.sv -----
// Frustum box culler: matrix storage, plane rebuild and box test sequencer.
// Load items leave the sequencer idle, so the next item can follow at once.
// A rebuild computes 24 plane coefficients, two clip entries each, with
// four passes of the shared multiplier per clip entry, then a wait and a take state.
// A box test runs each plane in turn until one rejects the box, then posts the result.
// Reset clears the matrices and planes to zero and sets box_size to 16.
module frustum_box_culler import fbc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [1:0]                   command,
    input  logic [3:0]                   entry_index,
    input  logic signed [ENTRY_W-1:0]    entry_value,
    input  logic signed [COORD_BITS-1:0] box_x,
    input  logic signed [COORD_BITS-1:0] box_y,
    input  logic signed [COORD_BITS-1:0] box_z,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         visible,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic signed [ENTRY_W-1:0] view_reg [MAT_N];
    logic signed [ENTRY_W-1:0] proj_reg [MAT_N];
    logic signed [COEF_W-1:0]  plane_reg [PLANE_N];
    logic [SIZE_W-1:0]         box_size_reg;

    state_t state_reg, state_next;
    logic [4:0] q_reg, q_next;
    logic [1:0] k_reg, k_next;
    logic       half_reg, half_next;
    logic signed [CLIP_W-1:0] w_reg, w_next;
    logic [2:0] p_reg, p_next;
    logic [2:0] s_reg, s_next;
    logic       nz_reg, nz_next;
    logic signed [CRD_W-1:0] start_reg [3];
    logic signed [CRD_W-1:0] end_reg [3];
    logic       out_valid_reg, out_valid_next;
    logic       visible_reg, visible_next;
    logic       vis_pend_reg, vis_pend_next;

    logic       accept;
    logic       plane_we;
    logic signed [COEF_W-1:0] plane_wdata;
    mac_ctrl_t  mac_ctrl;
    logic signed [OP_W-1:0]   op_a;
    logic signed [OP_W-1:0]   op_b;
    logic signed [COEF_W-1:0] addend;
    logic signed [ACC_W-1:0]  acc;

    logic [2:0] rb_p;
    logic [1:0] rb_c;
    logic signed [CLIP_W-1:0] clip;
    logic [1:0] cj;
    logic signed [COEF_W-1:0] cf;
    logic       cf_pos;
    logic signed [CRD_W-1:0] crd;
    cmd_t       cmd;

    assign cmd        = cmd_t'(command);
    assign accept     = cmd_valid && !cmd_stall;
    assign cmd_stall  = (state_reg != ST_IDLE);
    assign res_valid  = out_valid_reg;
    assign visible    = visible_reg;
    assign pready     = 1'b1;
    assign prdata     = 32'(box_size_reg);

    fbc_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .op_a   (op_a),
        .op_b   (op_b),
        .addend (addend),
        .acc    (acc)
    );

    // Config register; only one register exists, so every write lands on it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_size_reg <= SIZE_W'(16);
        end
        else if (psel && penable && pwrite && pready)
        begin
            box_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAT_N; i++)
            begin
                view_reg[i] <= '0;
                proj_reg[i] <= '0;
            end
            for (int i = 0; i < PLANE_N; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept && cmd == CMD_LOAD_VIEW)
            begin
                view_reg[entry_index] <= entry_value;
            end
            if (accept && cmd == CMD_LOAD_PROJ)
            begin
                proj_reg[entry_index] <= entry_value;
            end
            if (plane_we)
            begin
                plane_reg[q_reg] <= plane_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_TEST)
        begin
            start_reg[0] <= CRD_W'(box_x);
            start_reg[1] <= CRD_W'(box_y);
            start_reg[2] <= CRD_W'(box_z);
            end_reg[0]   <= CRD_W'(box_x) + $signed(CRD_W'(box_size_reg));
            end_reg[1]   <= CRD_W'(box_y) + $signed(CRD_W'(box_size_reg));
            end_reg[2]   <= CRD_W'(box_z) + $signed(CRD_W'(box_size_reg));
        end
        w_reg <= w_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            q_reg         <= '0;
            k_reg         <= '0;
            half_reg      <= 1'b0;
            p_reg         <= '0;
            s_reg         <= '0;
            nz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            visible_reg   <= 1'b0;
            vis_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            q_reg         <= q_next;
            k_reg         <= k_next;
            half_reg      <= half_next;
            p_reg         <= p_next;
            s_reg         <= s_next;
            nz_reg        <= nz_next;
            out_valid_reg <= out_valid_next;
            visible_reg   <= visible_next;
            vis_pend_reg  <= vis_pend_next;
        end
    end

    // Operand selection for the rebuild: clip[4j+c] uses view row j and projection column c.
    assign rb_p = q_reg[4:2];
    assign rb_c = half_reg ? rb_p[2:1] : 2'd3;
    assign clip = sat_clip(acc);

    // Operand selection for the box test: the low and high halves of each
    // coefficient are multiplied in turn, then the plane offset is added.
    assign cj     = s_reg[2:1];
    assign cf     = plane_reg[{p_reg, cj}];
    assign cf_pos = !cf[COEF_W-1] && (cf != '0);

    always_comb
    begin
        case (cj)
            2'd0:    crd = cf_pos ? end_reg[0] : start_reg[0];
            2'd1:    crd = cf_pos ? end_reg[1] : start_reg[1];
            2'd2:    crd = cf_pos ? end_reg[2] : start_reg[2];
            default: crd = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        half_next      = half_reg;
        w_next         = w_reg;
        p_next         = p_reg;
        s_next         = s_reg;
        nz_next        = nz_reg;
        vis_pend_next  = vis_pend_reg;
        visible_next   = visible_reg;
        out_valid_next = out_valid_reg;
        plane_we       = 1'b0;
        plane_wdata    = '0;
        mac_ctrl       = '0;
        op_a           = '0;
        op_b           = '0;
        addend         = '0;

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd == CMD_REBUILD)
                begin
                    q_next     = '0;
                    k_next     = '0;
                    half_next  = 1'b0;
                    state_next = ST_RB_ISSUE;
                end
                else if (accept && cmd == CMD_TEST)
                begin
                    p_next     = '0;
                    s_next     = '0;
                    state_next = ST_BX_ISSUE;
                end
            end
            ST_RB_ISSUE:
            begin
                mac_ctrl.issue = 1'b1;
                mac_ctrl.clear = (k_reg == 2'd0);
                mac_ctrl.term  = TERM_FLOOR;
                op_a           = OP_W'(view_reg[{q_reg[1:0], k_reg}]);
                op_b           = OP_W'(proj_reg[{k_reg, rb_c}]);
                k_next         = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_RB_WAIT;
                end
            end
            ST_RB_WAIT:
            begin
                state_next = ST_RB_TAKE;
            end
            ST_RB_TAKE:
            begin
                k_next = '0;
                if (!half_reg)
                begin
                    w_next     = clip;
                    half_next  = 1'b1;
                    state_next = ST_RB_ISSUE;
                end
                else
                begin
                    plane_we    = 1'b1;
                    plane_wdata = rb_p[0] ? (COEF_W'(w_reg) + COEF_W'(clip))
                                          : (COEF_W'(w_reg) - COEF_W'(clip));
                    half_next   = 1'b0;
                    if (q_reg == 5'(PLANE_N - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        q_next     = q_reg + 5'd1;
                        state_next = ST_RB_ISSUE;
                    end
                end
            end
            ST_BX_ISSUE:
            begin
                mac_ctrl.issue = 1'b1;
                mac_ctrl.clear = (s_reg == 3'd0);
                op_b           = OP_W'(crd);
                if (s_reg == 3'd6)
                begin
                    mac_ctrl.term = TERM_DIRECT;
                    addend        = cf;
                    state_next    = ST_BX_WAIT;
                end
                else if (!s_reg[0])
                begin
                    mac_ctrl.term = TERM_PLAIN;
                    op_a          = {1'b0, cf[LO_W-1:0]};
                end
                else
                begin
                    mac_ctrl.term = TERM_UPPER;
                    op_a          = OP_W'($signed(cf[COEF_W-1:LO_W]));
                end
                if (s_reg == 3'd0)
                begin
                    nz_next = (cf != '0);
                end
                else if (s_reg != 3'd6)
                begin
                    nz_next = nz_reg || (cf != '0);
                end
                s_next = s_reg + 3'd1;
            end
            ST_BX_WAIT:
            begin
                state_next = ST_BX_TAKE;
            end
            ST_BX_TAKE:
            begin
                s_next = '0;
                // A plane with a zero normal never rejects the box.
                if (nz_reg && acc <= 0)
                begin
                    vis_pend_next = 1'b0;
                    state_next    = ST_PUSH;
                end
                else if (p_reg == 3'd5)
                begin
                    vis_pend_next = 1'b1;
                    state_next    = ST_PUSH;
                end
                else
                begin
                    p_next     = p_reg + 3'd1;
                    state_next = ST_BX_ISSUE;
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_valid_next = 1'b1;
                    visible_next   = vis_pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- verif/tb_frustum_box_culler.sv -----
// Self-checking testbench of the frustum box culler with its own plane predictor.
module tb_frustum_box_culler;
    import fbc_pkg::*;

    localparam logic [1:0] REG_BOX_SIZE = 2'd0;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        cmd_t                        cmd;
        logic [3:0]                  idx;
        logic signed [ENTRY_W-1:0]   val;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } cull_item_t;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    logic [1:0] command;
    logic [3:0] entry_index;
    logic signed [ENTRY_W-1:0] entry_value;
    logic signed [COORD_BITS-1:0] box_x;
    logic signed [COORD_BITS-1:0] box_y;
    logic signed [COORD_BITS-1:0] box_z;
    logic res_valid;
    logic res_stall;
    logic visible;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    frustum_box_culler dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .command(command),
        .entry_index(entry_index), .entry_value(entry_value),
        .box_x(box_x), .box_y(box_y), .box_z(box_z),
        .res_valid(res_valid), .res_stall(res_stall), .visible(visible),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state.
    longint view_m[MAT_N];
    longint proj_m[MAT_N];
    longint planes[PLANE_N];
    int unsigned edge_len;

    cull_item_t pending_items[$];
    cull_item_t on_port;
    bit expected_visible[$];
    bit cmd_taken;
    bit failed;
    int snd_idle_pct;
    int rcv_stall_pct;
    int hold_left;

    always #1 clk = ~clk;

    function automatic void rebuild_planes();
        longint clip[16];
        longint acc;
        longint lim;
        int col;
        lim = (longint'(1) << 47) - 1;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                begin
                    acc += (view_m[4*r+k] * proj_m[4*k+c]) >>> FRAC_BITS;
                end
                if (acc > lim)
                begin
                    acc = lim;
                end
                else if (acc < -lim - 1)
                begin
                    acc = -lim - 1;
                end
                clip[4*r+c] = acc;
            end
        end
        for (int p = 0; p < 6; p++)
        begin
            col = p >> 1;
            for (int j = 0; j < 4; j++)
            begin
                planes[4*p+j] = (p & 1) ? clip[4*j+3] + clip[4*j+col]
                                        : clip[4*j+3] - clip[4*j+col];
            end
        end
    endfunction

    function automatic bit box_is_visible(longint sx, longint sy, longint sz);
        logic signed [127:0] acc;
        logic signed [127:0] coef;
        logic signed [127:0] crd;
        longint lo[3];
        longint hi[3];
        lo[0] = sx;
        lo[1] = sy;
        lo[2] = sz;
        for (int j = 0; j < 3; j++)
        begin
            hi[j] = lo[j] + longint'(edge_len);
        end
        for (int p = 0; p < 6; p++)
        begin
            if (planes[4*p] == 0 && planes[4*p+1] == 0 && planes[4*p+2] == 0)
            begin
                continue;
            end
            acc = planes[4*p+3];
            for (int j = 0; j < 3; j++)
            begin
                coef = planes[4*p+j];
                crd = (planes[4*p+j] > 0) ? hi[j] : lo[j];
                acc += coef * crd;
            end
            if (acc <= 0)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Prediction on acceptance and checking of results, both at the rising edge.
    always @(posedge clk)
    begin
        cmd_taken = rst_n && cmd_valid && !cmd_stall;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_visible.size() == 0)
            begin
                $display("%0t: unexpected result visible=%0b", $time, visible);
                failed = 1'b1;
            end
            else if (expected_visible[0] !== visible)
            begin
                $display("%0t: visible mismatch, expected %0b actual %0b",
                         $time, expected_visible[0], visible);
                failed = 1'b1;
                void'(expected_visible.pop_front());
            end
            else
            begin
                void'(expected_visible.pop_front());
            end
        end
        if (cmd_taken)
        begin
            case (on_port.cmd)
                CMD_LOAD_VIEW: view_m[on_port.idx] = longint'(on_port.val);
                CMD_LOAD_PROJ: proj_m[on_port.idx] = longint'(on_port.val);
                CMD_REBUILD: rebuild_planes();
                default: expected_visible.push_back(box_is_visible(
                    longint'(on_port.x), longint'(on_port.y), longint'(on_port.z)));
            endcase
        end
    end

    // Item driver.
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_taken))
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= snd_idle_pct)
            begin
                on_port <= pending_items[0];
                command <= pending_items[0].cmd;
                entry_index <= pending_items[0].idx;
                entry_value <= pending_items[0].val;
                box_x <= pending_items[0].x;
                box_y <= pending_items[0].y;
                box_z <= pending_items[0].z;
                void'(pending_items.pop_front());
                cmd_valid <= 1'b1;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    function automatic logic signed [ENTRY_W-1:0] pick_entry();
        case ($urandom_range(9))
            0: return ENTRY_W'($urandom);
            1: return 0;
            2: return 32'sh0001_0000;
            default: return ENTRY_W'($signed($urandom_range(6 * 65536)) - 3 * 65536);
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] pick_coord();
        if ($urandom_range(9) == 0)
        begin
            return COORD_BITS'($urandom);
        end
        return COORD_BITS'($signed($urandom_range(400)) - 200);
    endfunction

    task automatic add_item(cmd_t c, logic [3:0] i, logic signed [ENTRY_W-1:0] v,
                            logic signed [COORD_BITS-1:0] x,
                            logic signed [COORD_BITS-1:0] y,
                            logic signed [COORD_BITS-1:0] z);
        cull_item_t it;
        it.cmd = c;
        it.idx = i;
        it.val = v;
        it.x = x;
        it.y = y;
        it.z = z;
        pending_items.push_back(it);
    endtask

    task automatic add_random_scene(int n_tests);
        int n_loads;
        n_loads = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 32;
        for (int i = 0; i < n_loads; i++)
        begin
            add_item((n_loads == 32) ? ((i < 16) ? CMD_LOAD_VIEW : CMD_LOAD_PROJ)
                                     : cmd_t'($urandom_range(1)),
                     (n_loads == 32) ? i[3:0] : 4'($urandom), pick_entry(),
                     COORD_BITS'($urandom), COORD_BITS'($urandom),
                     COORD_BITS'($urandom));
        end
        add_item(CMD_REBUILD, 4'($urandom), ENTRY_W'($urandom), COORD_BITS'($urandom),
                 COORD_BITS'($urandom), COORD_BITS'($urandom));
        for (int i = 0; i < n_tests; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_item(cmd_t'($urandom_range(3)), 4'($urandom), ENTRY_W'($urandom),
                         COORD_BITS'($urandom), COORD_BITS'($urandom),
                         COORD_BITS'($urandom));
            end
            else
            begin
                add_item(CMD_TEST, 4'($urandom), ENTRY_W'($urandom), pick_coord(),
                         pick_coord(), pick_coord());
            end
        end
    endtask

    task automatic write_box_size(logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_BOX_SIZE;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        edge_len = value & 32'h7FF;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !cmd_valid);
        wait (expected_visible.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        command = CMD_LOAD_VIEW;
        entry_index = '0;
        entry_value = '0;
        box_x = '0;
        box_y = '0;
        box_z = '0;
        res_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_left = 0;
        failed = 1'b0;
        cmd_taken = 1'b0;
        edge_len = 16;
        for (int i = 0; i < MAT_N; i++)
        begin
            view_m[i] = 0;
            proj_m[i] = 0;
        end
        for (int i = 0; i < PLANE_N; i++)
        begin
            planes[i] = 0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Before any rebuild every box is visible, extremes included.
        add_item(CMD_TEST, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        add_item(CMD_TEST, 4'hF, 32'sh7FFFFFFF, 24'sh800000, 24'sh800000, 24'sh800000);
        // Identity view with a simple projection, then boxes on both sides.
        add_item(CMD_LOAD_VIEW, 0, 32'sh0001_0000, 0, 0, 0);
        add_item(CMD_LOAD_VIEW, 5, 32'sh0001_0000, 0, 0, 0);
        add_item(CMD_LOAD_VIEW, 10, 32'sh0001_0000, 0, 0, 0);
        add_item(CMD_LOAD_VIEW, 15, 32'sh0001_0000, 0, 0, 0);
        add_item(CMD_LOAD_PROJ, 0, 32'sh0001_0000, 0, 0, 0);
        add_item(CMD_LOAD_PROJ, 5, 32'sh0001_0000, 0, 0, 0);
        add_item(CMD_LOAD_PROJ, 14, 32'shFFFF_0000, 0, 0, 0);
        add_item(CMD_LOAD_PROJ, 11, 32'sh0000_8000, 0, 0, 0);
        add_item(CMD_REBUILD, 0, 0, 0, 0, 0);
        add_item(CMD_TEST, 0, 0, -8, -8, -100);
        add_item(CMD_TEST, 0, 0, 500, 500, -10);
        add_item(CMD_TEST, 0, 0, -8, -8, 50);
        add_item(CMD_TEST, 0, 0, 24'sh800000, 0, 24'sh7FFFFF);
        add_item(CMD_TEST, 0, 0, 24'sh7FFFFF, 24'sh800000, 24'sh800000);
        // Extreme entries load the most negative and most positive matrix values.
        add_item(CMD_LOAD_VIEW, 3, 32'sh8000_0000, 0, 0, 0);
        add_item(CMD_LOAD_PROJ, 15, 32'sh8000_0000, 0, 0, 0);
        add_item(CMD_LOAD_VIEW, 12, 32'sh7FFF_FFFF, 0, 0, 0);
        add_item(CMD_LOAD_PROJ, 3, 32'sh7FFF_FFFF, 0, 0, 0);
        add_item(CMD_REBUILD, 0, 0, 0, 0, 0);
        add_item(CMD_TEST, 0, 0, 3, -3, 7);
        add_item(CMD_TEST, 0, 0, 24'sh800000, 24'sh7FFFFF, 0);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_box_size(1);
                1: write_box_size(1024);
                2: write_box_size(0);
                3: write_box_size(2047);
                default: write_box_size($urandom_range(1, 64));
            endcase
            snd_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 73) : 0;
            rcv_stall_pct = (ph == 2) ? 73 : ((ph == 3) ? 12 : 0);
            add_random_scene(20);
            if (ph == 4)
            begin
                // Hold the receiver off while tests keep coming.
                wait (pending_items.size() < 20);
                hold_left = 300;
            end
            add_random_scene(20);
            drain();
        end
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        write_box_size(16);
        add_random_scene(30);
        drain();

        if (!failed && expected_visible.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
